// File: hdl/esrc_pkg.sv
package esrc_pkg;

  localparam int GRID_WIDTH_DEF  = 128;
  localparam int GRID_HEIGHT_DEF = 256;
  localparam int LABEL_COUNT_DEF = 5;
  localparam int STACK_DEPTH_DEF = 32768;

  localparam int DATA_W   = 24;
  localparam int NLAB     = 8;
  localparam int CELL_OCC  = 0;
  localparam int CELL_MARK = 4;

  typedef enum logic [1:0] {
    F_WRITE  = 2'd0,
    F_READ   = 2'd1,
    F_SCAN   = 2'd2,
    F_REMOVE = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_WRITE,
    OP_READ,
    OP_RES_RD,
    OP_CLR_CELL,
    OP_REM,
    OP_SCAN_INIT,
    OP_LEFT,
    OP_RIGHT,
    OP_LAB_NEXT,
    OP_CLR_VIS,
    OP_FILL_START,
    OP_POP,
    OP_NB_RD,
    OP_NB_CHK,
    OP_FILL_END,
    OP_MARK,
    OP_RES_SCAN,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_RDRES,
    S_REM,
    S_REM_DRAIN,
    S_LEFT,
    S_RIGHT,
    S_COL_DRAIN,
    S_LAB,
    S_VCLR,
    S_START,
    S_NB_RD,
    S_NB_CHK,
    S_FTEST,
    S_MARK,
    S_LABN,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PK_NONE,
    PK_REM,
    PK_MARK,
    PK_LEFT,
    PK_RIGHT
  } pend_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  swp_last;
    logic  row_last;
    logic  lab_done;
    logic  lab_go;
    logic  sp_zero;
    logic  k_last;
    logic  reached;
    logic  out_free;
  } dp_stat_t;

endpackage

// File: hdl/esrc_dp.sv
module esrc_dp #(
  parameter int GRID_WIDTH  = esrc_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = esrc_pkg::GRID_HEIGHT_DEF,
  parameter int LABEL_COUNT = esrc_pkg::LABEL_COUNT_DEF,
  parameter int STACK_DEPTH = esrc_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  esrc_pkg::dp_cmd_t              cmd,
  output esrc_pkg::dp_stat_t             st,
  input  logic [esrc_pkg::DATA_W-1:0]    in_tdata,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [esrc_pkg::DATA_W-1:0]    out_tdata
);
  import esrc_pkg::*;

  localparam int RB  = $clog2(GRID_HEIGHT);
  localparam int CB  = $clog2(GRID_WIDTH);
  localparam int AW  = RB + CB;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [4:0]    cell_mem [2**AW];
  logic          vis_mem  [2**AW];
  logic [AW-1:0] stk_mem  [STACK_DEPTH];

  logic [RB-1:0]  sr_r, sr_nxt;
  logic [CB-1:0]  sc_r, sc_nxt;
  pend_t          pk_r, pk_nxt;
  logic [AW-1:0]  pa_r;
  logic [RB-1:0]  pr_r;
  func_t          func_r;
  logic [AW-1:0]  adr_r;
  logic           ins_r;
  logic [4:0]     wcell_r;
  logic [NLAB-1:0] found_r, has_r;
  logic [RB-1:0]  lrow_r [NLAB];
  logic [3:0]     lab_r;
  logic [15:0]    total_r, cnt_r;
  logic           any_r, reached_r;
  logic [SPW-1:0] sp_r;
  logic [1:0]     k_r;
  logic [21:0]    res_r;
  logic           out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [4:0]     cell_q;
  logic           vis_q;
  logic [AW-1:0]  stk_q;

  logic [AW-1:0]  sa, cell_ra, nb_adr, start_adr;
  logic           swp_last, row_last;
  logic [RB-1:0]  cr, nr;
  logic [CB-1:0]  cc, nc;
  logic           nb_in, nb_ok, col_ok;
  logic [2:0]     lv;
  logic [16:0]    sum;
  logic [15:0]    row16, col16;
  logic           cell_we, vis_we, vis_wd, stk_we;
  logic [AW-1:0]  cell_wa, vis_wa;
  logic [4:0]     cell_wd;
  logic [SAW-1:0] stk_wa, stk_ra;
  logic [AW-1:0]  stk_wd;
  logic [SPW-1:0] sp_m1;

  assign sa       = {sr_r, sc_r};
  assign row_last = (sr_r == RB'(GRID_HEIGHT - 1));
  assign swp_last = row_last && (sc_r == CB'(GRID_WIDTH - 1));
  assign cr       = stk_q[AW-1:CB];
  assign cc       = stk_q[CB-1:0];
  assign lv       = cell_q[3:1];
  assign col_ok   = cell_q[CELL_OCC] && !cell_q[CELL_MARK] && ({1'b0, lv} < 4'(LABEL_COUNT));
  assign start_adr = {lrow_r[lab_r[2:0]], CB'(0)};
  assign sp_m1    = sp_r - SPW'(1);
  assign row16    = {8'b0, in_tdata[9:2]};
  assign col16    = {9'b0, in_tdata[16:10]};
  assign sum      = {1'b0, total_r} + {1'b0, cnt_r};

  // neighbor of the popped cell in down, up, right, left order
  always_comb begin
    nr = cr;
    nc = cc;
    nb_in = 1'b0;
    case (k_r)
      2'd0: begin nr = cr + RB'(1); nb_in = (cr != RB'(GRID_HEIGHT - 1)); end
      2'd1: begin nr = cr - RB'(1); nb_in = (cr != RB'(0)); end
      2'd2: begin nc = cc + CB'(1); nb_in = (cc != CB'(GRID_WIDTH - 1)); end
      2'd3: begin nc = cc - CB'(1); nb_in = (cc != CB'(0)); end
      default: nb_in = 1'b0;
    endcase
  end
  assign nb_adr = {nr, nc};
  assign nb_ok  = nb_in && !vis_q && cell_q[CELL_OCC] && !cell_q[CELL_MARK]
                  && (lv == lab_r[2:0]) && (sp_r < SPW'(STACK_DEPTH));

  always_comb begin
    case (cmd.op)
      OP_READ:  cell_ra = adr_r;
      OP_LEFT:  cell_ra = {sr_r, CB'(0)};
      OP_RIGHT: cell_ra = {sr_r, CB'(GRID_WIDTH - 1)};
      OP_NB_RD: cell_ra = nb_adr;
      default:  cell_ra = sa;
    endcase
  end

  // sweep counters wrap to zero after the last address
  always_comb begin
    sr_nxt = sr_r;
    sc_nxt = sc_r;
    pk_nxt = PK_NONE;
    case (cmd.op)
      OP_CLR_CELL, OP_CLR_VIS, OP_REM, OP_MARK: begin
        if (sc_r == CB'(GRID_WIDTH - 1)) begin
          sc_nxt = '0;
          sr_nxt = row_last ? '0 : sr_r + RB'(1);
        end else begin
          sc_nxt = sc_r + CB'(1);
        end
        if (cmd.op == OP_REM) pk_nxt = PK_REM;
        if (cmd.op == OP_MARK) pk_nxt = PK_MARK;
      end
      OP_LEFT, OP_RIGHT: begin
        sr_nxt = row_last ? '0 : sr_r + RB'(1);
        pk_nxt = (cmd.op == OP_LEFT) ? PK_LEFT : PK_RIGHT;
      end
      default: ;
    endcase
  end

  always_comb begin
    cell_we = 1'b0;
    cell_wa = pa_r;
    cell_wd = '0;
    if (pk_r == PK_REM && cell_q[CELL_MARK]) begin
      cell_we = 1'b1;
      cell_wd = {1'b0, cell_q[3:1], 1'b0};
    end else if (pk_r == PK_MARK && vis_q) begin
      cell_we = 1'b1;
      cell_wd = cell_q | 5'b10000;
    end else if (cmd.op == OP_CLR_CELL) begin
      cell_we = 1'b1;
      cell_wa = sa;
    end else if (cmd.op == OP_WRITE && ins_r) begin
      cell_we = 1'b1;
      cell_wa = adr_r;
      cell_wd = wcell_r;
    end
  end

  always_comb begin
    vis_we = 1'b0;
    vis_wa = sa;
    vis_wd = 1'b0;
    stk_we = 1'b0;
    stk_wa = sp_r[SAW-1:0];
    stk_wd = nb_adr;
    case (cmd.op)
      OP_CLR_VIS: vis_we = 1'b1;
      OP_FILL_START: begin
        vis_we = 1'b1;
        vis_wa = start_adr;
        vis_wd = 1'b1;
        stk_we = 1'b1;
        stk_wa = '0;
        stk_wd = start_adr;
      end
      OP_NB_CHK: begin
        vis_we = nb_ok;
        vis_wa = nb_adr;
        vis_wd = 1'b1;
        stk_we = nb_ok;
      end
      default: ;
    endcase
  end
  assign stk_ra = sp_m1[SAW-1:0];

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_q <= cell_mem[cell_ra];
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[cell_ra];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (cmd.op == OP_POP) stk_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r        <= '0;
      sc_r        <= '0;
      pk_r        <= PK_NONE;
      found_r     <= '0;
      has_r       <= '0;
      lab_r       <= '0;
      total_r     <= '0;
      any_r       <= 1'b0;
      sp_r        <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      reached_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sr_r <= sr_nxt;
      sc_r <= sc_nxt;
      pk_r <= pk_nxt;
      if (pk_r == PK_LEFT && col_ok && !found_r[lv]) found_r[lv] <= 1'b1;
      if (pk_r == PK_RIGHT && col_ok) has_r[lv] <= 1'b1;
      case (cmd.op)
        OP_SCAN_INIT: begin
          found_r <= '0;
          has_r   <= '0;
          lab_r   <= '0;
          total_r <= '0;
          any_r   <= 1'b0;
        end
        OP_LAB_NEXT: lab_r <= lab_r + 4'd1;
        OP_FILL_START: begin
          sp_r      <= SPW'(1);
          cnt_r     <= 16'd1;
          reached_r <= 1'b0;
        end
        OP_POP: begin
          sp_r <= sp_m1;
          k_r  <= '0;
        end
        OP_NB_CHK: begin
          k_r <= k_r + 2'd1;
          if (nb_ok) begin
            sp_r <= sp_r + SPW'(1);
            if (cnt_r != 16'hFFFF) cnt_r <= cnt_r + 16'd1;
            if (nc == CB'(GRID_WIDTH - 1)) reached_r <= 1'b1;
          end
        end
        OP_FILL_END: begin
          if (reached_r) begin
            total_r <= sum[16] ? 16'hFFFF : sum[15:0];
            any_r   <= 1'b1;
          end
        end
        default: ;
      endcase
      if (cmd.op == OP_EMIT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pa_r <= sa;
    pr_r <= sr_r;
    if (pk_r == PK_LEFT && col_ok && !found_r[lv]) lrow_r[lv] <= pr_r;
    case (cmd.op)
      OP_ACCEPT: begin
        func_r  <= func_t'(in_tdata[1:0]);
        ins_r   <= (11'(row16) < 11'(GRID_HEIGHT)) && (11'(col16) < 11'(GRID_WIDTH));
        adr_r   <= {row16[RB-1:0], col16[CB-1:0]};
        wcell_r <= {in_tdata[21], in_tdata[20:18], in_tdata[17]};
        res_r   <= '0;
      end
      OP_RES_RD:   res_r <= ins_r ? {17'b0, cell_q} : '0;
      OP_RES_SCAN: res_r <= {any_r, total_r, 5'b0};
      OP_EMIT:     out_data_r <= {2'b0, res_r};
      default: ;
    endcase
  end

  assign st.func     = func_r;
  assign st.swp_last = swp_last;
  assign st.row_last = row_last;
  assign st.lab_done = (lab_r == 4'(LABEL_COUNT));
  assign st.lab_go   = found_r[lab_r[2:0]] && has_r[lab_r[2:0]];
  assign st.sp_zero  = (sp_r == '0);
  assign st.k_last   = (k_r == 2'd3);
  assign st.reached  = reached_r;
  assign st.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hdl/esrc_ctrl.sv
module esrc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  esrc_pkg::dp_stat_t st,
  output esrc_pkg::dp_cmd_t  cmd
);
  import esrc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    in_tready = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR_CELL;
        if (st.swp_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st.func)
          F_WRITE: begin
            cmd.op    = OP_WRITE;
            state_nxt = S_OUT;
          end
          F_READ: begin
            cmd.op    = OP_READ;
            state_nxt = S_RDRES;
          end
          F_SCAN: begin
            cmd.op    = OP_SCAN_INIT;
            state_nxt = S_LEFT;
          end
          F_REMOVE: state_nxt = S_REM;
          default:  state_nxt = S_OUT;
        endcase
      end
      S_RDRES: begin
        cmd.op    = OP_RES_RD;
        state_nxt = S_OUT;
      end
      S_REM: begin
        cmd.op = OP_REM;
        if (st.swp_last) state_nxt = S_REM_DRAIN;
      end
      S_REM_DRAIN: state_nxt = S_OUT;
      S_LEFT: begin
        cmd.op = OP_LEFT;
        if (st.row_last) state_nxt = S_RIGHT;
      end
      S_RIGHT: begin
        cmd.op = OP_RIGHT;
        if (st.row_last) state_nxt = S_COL_DRAIN;
      end
      S_COL_DRAIN: state_nxt = S_LAB;
      S_LAB: begin
        if (st.lab_done) begin
          cmd.op    = OP_RES_SCAN;
          state_nxt = S_OUT;
        end else if (st.lab_go) begin
          state_nxt = S_VCLR;
        end else begin
          cmd.op = OP_LAB_NEXT;
        end
      end
      S_VCLR: begin
        cmd.op = OP_CLR_VIS;
        if (st.swp_last) state_nxt = S_START;
      end
      S_START: begin
        cmd.op    = OP_FILL_START;
        state_nxt = S_FTEST;
      end
      S_NB_RD: begin
        cmd.op    = OP_NB_RD;
        state_nxt = S_NB_CHK;
      end
      S_NB_CHK: begin
        cmd.op    = OP_NB_CHK;
        state_nxt = st.k_last ? S_FTEST : S_NB_RD;
      end
      // pop the next cell or close the fill when the stack is empty
      S_FTEST: begin
        if (st.sp_zero) begin
          cmd.op    = OP_FILL_END;
          state_nxt = st.reached ? S_MARK : S_LABN;
        end else begin
          cmd.op    = OP_POP;
          state_nxt = S_NB_RD;
        end
      end
      S_MARK: begin
        cmd.op = OP_MARK;
        if (st.swp_last) state_nxt = S_LABN;
      end
      S_LABN: begin
        cmd.op    = OP_LAB_NEXT;
        state_nxt = S_LAB;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hdl/edge_spanning_region_clear_top.sv
// Edge-spanning region clear on a GRID_HEIGHT x GRID_WIDTH cell grid held in on-chip
// memory. One word is taken at a time: a cell write goes to the memory, and a cell
// read is registered into the result register. Remove sweeps the grid once. A scan
// reads the left and right edge columns, then for every label with a candidate region
// clears the visited map and floods the region from the cells taken off the stack, one
// memory port per step; a region that reaches the right edge costs one more grid sweep to
// mark. After reset the cell memory is cleared, during which in_tready stays low.
module edge_spanning_region_clear_top #(
  parameter int GRID_WIDTH  = esrc_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = esrc_pkg::GRID_HEIGHT_DEF,
  parameter int LABEL_COUNT = esrc_pkg::LABEL_COUNT_DEF,
  parameter int STACK_DEPTH = esrc_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // func[1:0], row[9:2], col[16:10], occupied[17], label[20:18], mark[21]
  input  logic [esrc_pkg::DATA_W-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // cell_occupied[0], cell_label[3:1], cell_mark[4], cleared_cells[20:5], any_cleared[21]
  output logic [esrc_pkg::DATA_W-1:0] out_tdata
);
  import esrc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  esrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  esrc_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .LABEL_COUNT (LABEL_COUNT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hdl/esrc_checker.sv
module esrc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [esrc_pkg::DATA_W-1:0] in_tdata,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [esrc_pkg::DATA_W-1:0] out_tdata
);

  // one word in flight at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a word is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // a result carries either cell fields or scan fields, never both
  a_fields_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[4:0] == 5'd0) || (out_tdata[21:5] == 17'd0)))
    else $error("cell and scan fields both set");

  a_count_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[21]) |-> (out_tdata[20:5] == 16'd0))
    else $error("cleared count without spanning region");

endmodule

bind edge_spanning_region_clear_top esrc_checker u_esrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
